// File: hdl/lgds_pkg.sv
// Shared types, constants and the trig table builder for the likelihood grid.
// Used by every module of the block; depends on nothing.
package lgds_pkg;

  localparam int MAP_DIM            = 256;
  localparam int RADIUS_MAX         = 16;
  localparam int CIRCLE_SEGMENTS    = 47;
  localparam int TRIG_FRACTION_BITS = 14;
  localparam int QUEUE_DEPTH        = 2;

  localparam int CELL_W   = $clog2(MAP_DIM);
  localparam int ADDR_W   = 2 * CELL_W;
  localparam int RAD_W    = $clog2(RADIUS_MAX);
  localparam int SEG_W    = $clog2(CIRCLE_SEGMENTS + 1);
  localparam int TRIG_W   = TRIG_FRACTION_BITS + 2;
  localparam int STAMP_W  = TRIG_FRACTION_BITS + CELL_W + 2;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_LOAD   = 3'd1;
  localparam logic [2:0] CMD_DRAW   = 3'd2;
  localparam logic [2:0] CMD_SCORE  = 3'd3;
  localparam logic [2:0] CMD_RDCLR  = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_BAD_IDX = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_CPM      = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_RADII    = 3'd5;

  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int SDIV [6] = '{156, 110, 72, 42, 20, 6};
  localparam int CDIV [7] = '{182, 132, 90, 56, 30, 12, 2};

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [15:0]        cpm;
    logic [8:0]         w_eff;
    logic [8:0]         h_eff;
    logic [RAD_W:0]     rc_eff;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic              in_map;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic [3:0]        wi;
    logic [7:0]        wv;
  } item_t;

  // Fixed-point cos/sin of segment n, built at elaboration.
  function automatic logic signed [TRIG_W-1:0] trig_entry(int n, bit want_sin);
    longint unsigned p, r, a, a2;
    longint t, s, c, mag, res;
    int q;
    bit neg;
    p = ((longint'(n) << 32) + CIRCLE_SEGMENTS / 2) / CIRCLE_SEGMENTS;
    q = int'((p >> 30) & 64'd3);
    r = p & ((64'd1 << 30) - 64'd1);
    a = (r * longint'(HALF_PI_Q30)) >> 30;
    a2 = (a * a) >> 30;
    t = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      t = Q30_ONE - longint'((a2 * longint'(t)) >> 30) / SDIV[k];
      if (t < 0) t = 0;
    end
    s = longint'((a * longint'(t)) >> 30);
    t = Q30_ONE;
    for (int k = 0; k < 7; k++) begin
      t = Q30_ONE - longint'((a2 * longint'(t)) >> 30) / CDIV[k];
      if (t < 0) t = 0;
    end
    c = t;
    case (q)
      0: begin mag = want_sin ? s : c; neg = 1'b0; end
      1: begin mag = want_sin ? c : s; neg = !want_sin; end
      2: begin mag = want_sin ? s : c; neg = 1'b1; end
      default: begin mag = want_sin ? c : s; neg = want_sin; end
    endcase
    res = (mag + (64'sd1 << (29 - TRIG_FRACTION_BITS))) >>> (30 - TRIG_FRACTION_BITS);
    if (neg) res = -res;
    return res[TRIG_W-1:0];
  endfunction

endpackage

// File: hdl/lgds_front.sv
// Front end: accepts items, converts the point to a cell and classifies it.
// Depends on lgds_pkg; feeds lgds_queue.
module lgds_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lgds_pkg::cfg_t       cfg,
  input  logic                 hold,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [2:0]           in_command,
  input  logic signed [23:0]   in_point_x,
  input  logic signed [23:0]   in_point_y,
  input  logic [3:0]           in_weight_index,
  input  logic [7:0]           in_weight_value,
  output logic                 q_push,
  input  logic                 q_full,
  output lgds_pkg::item_t      q_item
);
  import lgds_pkg::*;

  logic               a_valid_r;
  logic [2:0]         a_cmd_r;
  logic [3:0]         a_wi_r;
  logic [7:0]         a_wv_r;
  logic signed [41:0] a_px_r, a_py_r;

  logic signed [24:0] dx, dy;
  logic signed [41:0] px_nxt, py_nxt;
  logic signed [25:0] cell_x, cell_y;
  logic signed [41:0] bx, by;
  logic               accept, in_x, in_y;

  assign in_full = hold || (a_valid_r && q_full);
  assign accept  = in_push && !in_full;
  assign q_push  = a_valid_r && !q_full;

  assign dx = {in_point_x[23], in_point_x} - {cfg.origin_x[23], cfg.origin_x};
  assign dy = {in_point_y[23], in_point_y} - {cfg.origin_y[23], cfg.origin_y};
  assign px_nxt = dx * $signed({1'b0, cfg.cpm});
  assign py_nxt = dy * $signed({1'b0, cfg.cpm});

  // truncate toward zero
  assign bx = a_px_r + (a_px_r[41] ? 42'sd65535 : 42'sd0);
  assign by = a_py_r + (a_py_r[41] ? 42'sd65535 : 42'sd0);
  assign cell_x = bx[41:16];
  assign cell_y = by[41:16];
  assign in_x = !cell_x[25] && (cell_x[24:0] < {16'd0, cfg.w_eff});
  assign in_y = !cell_y[25] && (cell_y[24:0] < {16'd0, cfg.h_eff});

  always_comb begin
    q_item.cmd    = a_cmd_r;
    q_item.in_map = in_x && in_y;
    q_item.cx     = cell_x[CELL_W-1:0];
    q_item.cy     = cell_y[CELL_W-1:0];
    q_item.wi     = a_wi_r;
    q_item.wv     = a_wv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (q_push) begin
      a_valid_r <= 1'b0;
    end
    if (accept) begin
      a_cmd_r <= in_command;
      a_wi_r  <= in_weight_index;
      a_wv_r  <= in_weight_value;
      a_px_r  <= px_nxt;
      a_py_r  <= py_nxt;
    end
  end

endmodule

// File: hdl/lgds_queue.sv
// Short queue of classified items between front and back end.
// Depends on lgds_pkg.
module lgds_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lgds_pkg::item_t wr_item,
  output logic            full,
  input  logic            pop,
  output lgds_pkg::item_t rd_item,
  output logic            empty
);
  import lgds_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    count_r;

  assign full    = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
    if (push) slots_r[wr_ptr_r] <= wr_item;
  end

endmodule

// File: hdl/lgds_back.sv
// Back end: grid memory, weight table, score, circle stamping and results.
// Depends on lgds_pkg; takes items from lgds_queue.
module lgds_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lgds_pkg::cfg_t           cfg,
  input  logic                     q_empty,
  input  lgds_pkg::item_t          q_item,
  output logic                     q_pop,
  output logic                     init_busy,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [31:0]              out_score,
  output logic [1:0]               out_status
);
  import lgds_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_DRAW, S_DRAIN, S_SCORE} state_t;

  state_t            state_r;
  logic              init_r;
  item_t             cur_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [SEG_W-1:0]  seg_r;
  logic [RAD_W-1:0]  rad_r;
  logic [31:0]       score_r;
  logic [7:0]        weight_r [RADIUS_MAX];
  logic              out_valid_r;
  logic [31:0]       out_score_r;
  logic [1:0]        out_status_r;

  logic [7:0]        grid_mem [MAP_DIM * MAP_DIM];
  logic [7:0]        rd_r;
  logic              p_valid_r, last_we_r;
  logic [ADDR_W-1:0] p_addr_r, last_addr_r;
  logic [7:0]        p_w_r, last_wd_r;

  logic signed [TRIG_W-1:0] cos_lut [CIRCLE_SEGMENTS + 1];
  logic signed [TRIG_W-1:0] sin_lut [CIRCLE_SEGMENTS + 1];

  for (genvar g = 0; g <= CIRCLE_SEGMENTS; g++) begin : g_trig
    localparam logic signed [TRIG_W-1:0] COS_V = trig_entry(g, 1'b0);
    localparam logic signed [TRIG_W-1:0] SIN_V = trig_entry(g, 1'b1);
    assign cos_lut[g] = COS_V;
    assign sin_lut[g] = SIN_V;
  end

  logic                      slot_free, start;
  logic signed [STAMP_W-1:0] sum_x, sum_y, mag_x, mag_y;
  logic [STAMP_W-TRIG_FRACTION_BITS-1:0] qx, qy;
  logic                      st_in;
  logic [ADDR_W-1:0]         st_addr;
  logic [7:0]                old_v, new_v;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_wa, mem_ra;
  logic [7:0]                mem_wd;
  logic [32:0]               sat_sum;
  logic                      last_stamp;

  assign slot_free = !out_valid_r || out_pop;
  assign start     = (state_r == S_IDLE) && !init_r && !q_empty && slot_free;
  assign q_pop     = start;
  assign init_busy = init_r;
  assign out_empty = !out_valid_r;
  assign out_score = out_score_r;
  assign out_status = out_status_r;

  // stamp position, truncated toward zero
  always_comb begin
    sum_x = $signed({2'b00, cur_r.cx, {TRIG_FRACTION_BITS{1'b0}}})
          + STAMP_W'(cos_lut[seg_r] * $signed({1'b0, rad_r}));
    sum_y = $signed({2'b00, cur_r.cy, {TRIG_FRACTION_BITS{1'b0}}})
          + STAMP_W'(sin_lut[seg_r] * $signed({1'b0, rad_r}));
    mag_x = sum_x[STAMP_W-1] ? -sum_x : sum_x;
    mag_y = sum_y[STAMP_W-1] ? -sum_y : sum_y;
    qx = mag_x[STAMP_W-1:TRIG_FRACTION_BITS];
    qy = mag_y[STAMP_W-1:TRIG_FRACTION_BITS];
    st_in = (!sum_x[STAMP_W-1] || qx == '0) && (!sum_y[STAMP_W-1] || qy == '0)
          && (qx < (STAMP_W-TRIG_FRACTION_BITS)'(cfg.w_eff))
          && (qy < (STAMP_W-TRIG_FRACTION_BITS)'(cfg.h_eff));
    st_addr = {qx[CELL_W-1:0], qy[CELL_W-1:0]};
  end

  assign last_stamp = (seg_r == SEG_W'(CIRCLE_SEGMENTS))
                   && ({1'b0, rad_r} == cfg.rc_eff - 1'b1);

  always_comb begin
    old_v = (last_we_r && last_addr_r == p_addr_r) ? last_wd_r : rd_r;
    new_v = (old_v < p_w_r) ? p_w_r : old_v;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = 8'd0;
    end else begin
      mem_we = p_valid_r;
      mem_wa = p_addr_r;
      mem_wd = new_v;
    end
    mem_ra = (state_r == S_DRAW) ? st_addr : {q_item.cx, q_item.cy};
    sat_sum = {1'b0, score_r} + {25'd0, rd_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_wa] <= mem_wd;
    rd_r <= grid_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      init_r      <= 1'b1;
      clr_addr_r  <= '0;
      score_r     <= '0;
      out_valid_r <= 1'b0;
      p_valid_r   <= 1'b0;
      last_we_r   <= 1'b0;
      for (int i = 0; i < RADIUS_MAX; i++) weight_r[i] <= 8'd0;
    end else begin
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      last_we_r   <= p_valid_r;
      last_addr_r <= p_addr_r;
      last_wd_r   <= new_v;
      p_valid_r   <= (state_r == S_DRAW) && st_in;
      p_addr_r    <= st_addr;
      p_w_r       <= weight_r[rad_r];
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cur_r        <= q_item;
            out_score_r  <= score_r;
            out_status_r <= ST_DONE;
            seg_r        <= '0;
            rad_r        <= '0;
            clr_addr_r   <= '0;
            case (q_item.cmd)
              CMD_CLEAR: state_r <= S_CLEAR;
              CMD_LOAD: begin
                out_valid_r <= 1'b1;
                if ({1'b0, q_item.wi} >= 5'(RADIUS_MAX)) out_status_r <= ST_BAD_IDX;
                else weight_r[q_item.wi[RAD_W-1:0]] <= q_item.wv;
              end
              CMD_DRAW: begin
                if (!q_item.in_map) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_OUTSIDE;
                end else if (cfg.rc_eff == '0) begin
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_DRAW;
                end
              end
              CMD_SCORE: begin
                if (!q_item.in_map) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_OUTSIDE;
                end else begin
                  state_r <= S_SCORE;
                end
              end
              CMD_RDCLR: begin
                out_valid_r <= 1'b1;
                score_r     <= '0;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (&clr_addr_r) begin
            state_r <= S_IDLE;
            if (init_r) init_r <= 1'b0;
            else out_valid_r <= 1'b1;
          end
        end
        S_DRAW: begin
          if (seg_r == SEG_W'(CIRCLE_SEGMENTS)) begin
            seg_r <= '0;
            rad_r <= rad_r + 1'b1;
          end else begin
            seg_r <= seg_r + 1'b1;
          end
          if (last_stamp) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_SCORE: begin
          score_r      <= sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
          out_score_r  <= sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/likelihood_grid_draw_and_score.sv
// Likelihood grid draw and score: top level with configuration registers.
// Clear sweeps every grid cell, and draw stamps 48 points on each radius in turn;
// the back end takes one item at a time.
// Draw rate is set by the grid memory, with one read and one write port: one stamped cell per cycle.
// rst_n is synchronous; after reset a pass over all 65536 cells zeroes the grid, full held high.
// Depends on lgds_pkg, lgds_front, lgds_queue, lgds_back.
module likelihood_grid_draw_and_score (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_command,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic [3:0]         in_weight_index,
  input  logic [7:0]         in_weight_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [31:0]        out_score,
  output logic [1:0]         out_status
);
  import lgds_pkg::*;

  logic signed [23:0] origin_x_r, origin_y_r;
  logic [15:0]        cpm_r;
  logic [8:0]         width_r, height_r;
  logic [4:0]         radii_r;
  cfg_t               cfg;
  logic               q_push, q_full, q_pop, q_empty, init_busy;
  item_t              q_wr, q_rd;

  always_comb begin
    cfg.origin_x = origin_x_r;
    cfg.origin_y = origin_y_r;
    cfg.cpm      = cpm_r;
    cfg.w_eff    = (width_r > 9'(MAP_DIM)) ? 9'(MAP_DIM) : width_r;
    cfg.h_eff    = (height_r > 9'(MAP_DIM)) ? 9'(MAP_DIM) : height_r;
    cfg.rc_eff   = ({1'b0, radii_r} > 6'(RADIUS_MAX)) ? (RAD_W+1)'(RADIUS_MAX)
                                                       : (RAD_W+1)'(radii_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      cpm_r      <= 16'd5120;
      width_r    <= 9'd256;
      height_r   <= 9'd256;
      radii_r    <= 5'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_wdata;
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        REG_CPM:      cpm_r      <= cfg_wdata[15:0];
        REG_WIDTH:    width_r    <= cfg_wdata[8:0];
        REG_HEIGHT:   height_r   <= cfg_wdata[8:0];
        REG_RADII:    radii_r    <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  lgds_front u_front (
    .clk, .rst_n, .cfg, .hold(init_busy),
    .in_push, .in_full, .in_command, .in_point_x, .in_point_y,
    .in_weight_index, .in_weight_value,
    .q_push, .q_full, .q_item(q_wr)
  );

  lgds_queue u_queue (
    .clk, .rst_n, .push(q_push), .wr_item(q_wr), .full(q_full),
    .pop(q_pop), .rd_item(q_rd), .empty(q_empty)
  );

  lgds_back u_back (
    .clk, .rst_n, .cfg, .q_empty, .q_item(q_rd), .q_pop, .init_busy,
    .out_empty, .out_pop, .out_score, .out_status
  );

endmodule

// File: tb/sv/tb_likelihood_grid_draw_and_score.sv
// Testbench for likelihood_grid_draw_and_score: directed table, then random traffic
// over several register settings, checked against a behavioral grid model.
// Depends on lgds_pkg and the likelihood_grid_draw_and_score RTL.
`timescale 1ns / 1ps

module tb_likelihood_grid_draw_and_score;
  import lgds_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;
  localparam int SEGS = 47;
  localparam int FRAC = 14;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [3:0]         wi;
    logic [7:0]         wv;
  } grid_op_t;

  typedef struct {
    logic [31:0] score;
    logic [1:0]  status;
  } grid_reply_t;

  typedef struct {
    grid_op_t    op;
    bit          typed;
    grid_reply_t reply;
  } row_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_wdata = '0;
  logic               in_push = 0;
  logic               in_full;
  logic [2:0]         in_command = '0;
  logic signed [23:0] in_point_x = '0;
  logic signed [23:0] in_point_y = '0;
  logic [3:0]         in_weight_index = '0;
  logic [7:0]         in_weight_value = '0;
  logic               out_empty;
  logic               out_pop = 0;
  logic [31:0]        out_score;
  logic [1:0]         out_status;

  likelihood_grid_draw_and_score DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // grid model state
  byte unsigned grid_mem [MAP_DIM*MAP_DIM];
  byte unsigned weights [RADIUS_MAX];
  logic [31:0]  score_acc;
  longint       org_x, org_y, cpm, wdim, hdim, rcnt;
  longint       cos_q [SEGS+1];
  longint       sin_q [SEGS+1];

  grid_reply_t  pending [$];
  int           fail_count = 0;
  int           accepted = 0;
  int           checked = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           quiet_cycles = 0;
  bit           took_in, took_out;

  function automatic longint shr_trunc(longint v, int sh);
    return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
  endfunction

  function automatic longint sx24(longint v);
    v = v & 64'hFFFFFF;
    return (v >= 64'h800000) ? v - 64'h1000000 : v;
  endfunction

  function automatic longint rnd_q(longint mag);
    return (mag + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic void build_circle();
    longint p, r, a, a2, t, s, c, mag, rnd;
    int q;
    int sd [6];
    int cd [7];
    sd = '{156, 110, 72, 42, 20, 6};
    cd = '{182, 132, 90, 56, 30, 12, 2};
    for (int n = 0; n <= SEGS; n++) begin
      p = ((longint'(n) << 32) + SEGS / 2) / SEGS;
      q = int'((p >> 30) & 3);
      r = p & ((64'sd1 << 30) - 1);
      a = (r * 64'sd1686629713) >>> 30;
      a2 = (a * a) >>> 30;
      t = 64'sd1 << 30;
      for (int k = 0; k < 6; k++) begin
        t = (64'sd1 << 30) - ((a2 * t) >>> 30) / sd[k];
        if (t < 0) t = 0;
      end
      s = (a * t) >>> 30;
      t = 64'sd1 << 30;
      for (int k = 0; k < 7; k++) begin
        t = (64'sd1 << 30) - ((a2 * t) >>> 30) / cd[k];
        if (t < 0) t = 0;
      end
      c = t;
      case (q)
        0: begin cos_q[n] = rnd_q(c); sin_q[n] = rnd_q(s); end
        1: begin cos_q[n] = -rnd_q(s); sin_q[n] = rnd_q(c); end
        2: begin cos_q[n] = -rnd_q(c); sin_q[n] = -rnd_q(s); end
        default: begin cos_q[n] = rnd_q(s); sin_q[n] = -rnd_q(c); end
      endcase
    end
  endfunction

  function automatic longint eff(longint v);
    return (v > MAP_DIM) ? MAP_DIM : v;
  endfunction

  function automatic bit on_map(longint cx, longint cy);
    return cx >= 0 && cy >= 0 && cx < eff(wdim) && cy < eff(hdim);
  endfunction

  function automatic grid_reply_t grid_predict(grid_op_t op);
    grid_reply_t rep;
    longint cx, cy, gx, gy, rc;
    byte unsigned w, v;
    cx = shr_trunc((longint'(op.px) - org_x) * cpm, 16);
    cy = shr_trunc((longint'(op.py) - org_y) * cpm, 16);
    rep.status = ST_DONE;
    case (op.cmd)
      CMD_CLEAR: foreach (grid_mem[i]) grid_mem[i] = 0;
      CMD_LOAD: weights[op.wi] = op.wv;
      CMD_DRAW: begin
        if (!on_map(cx, cy)) rep.status = ST_OUTSIDE;
        else begin
          rc = (rcnt > RADIUS_MAX) ? RADIUS_MAX : rcnt;
          for (int r = 0; r < rc; r++) begin
            w = weights[r];
            for (int n = 0; n <= SEGS; n++) begin
              gx = shr_trunc(cx * (64'sd1 << FRAC) + cos_q[n] * r, FRAC);
              gy = shr_trunc(cy * (64'sd1 << FRAC) + sin_q[n] * r, FRAC);
              if (on_map(gx, gy) && grid_mem[gx*MAP_DIM+gy] < w)
                grid_mem[gx*MAP_DIM+gy] = w;
            end
          end
        end
      end
      CMD_SCORE: begin
        if (!on_map(cx, cy)) rep.status = ST_OUTSIDE;
        else begin
          v = grid_mem[cx*MAP_DIM+cy];
          score_acc = (score_acc > 32'hFFFFFFFF - v) ? 32'hFFFFFFFF : score_acc + v;
        end
      end
      default: ;
    endcase
    rep.score = score_acc;
    if (op.cmd == CMD_RDCLR) score_acc = '0;
    return rep;
  endfunction

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val[23:0];
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      REG_ORIGIN_X: org_x = sx24(val);
      REG_ORIGIN_Y: org_y = sx24(val);
      REG_CPM:      cpm = val & 64'hFFFF;
      REG_WIDTH:    wdim = val & 64'h1FF;
      REG_HEIGHT:   hdim = val & 64'h1FF;
      REG_RADII:    rcnt = val & 64'h1F;
      default: ;
    endcase
  endtask

  task automatic push_op(grid_op_t op, bit typed, grid_reply_t want);
    grid_reply_t rep;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_push = 1;
    in_command = op.cmd;
    in_point_x = op.px;
    in_point_y = op.py;
    in_weight_index = op.wi;
    in_weight_value = op.wv;
    @(posedge clk);
    while (in_full) @(posedge clk);
    rep = grid_predict(op);
    pending.insert(pending.size(), typed ? want : rep);
    accepted++;
    @(negedge clk);
    in_push = 0;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [23:0] coord(longint org, longint dim);
    longint cell_idx, d;
    if ($urandom_range(99) < 20) return 24'($urandom);
    cell_idx = longint'($urandom_range(eff(dim) + 1)) - 1;
    d = (cell_idx * 65536 + $urandom_range(65535)) / ((cpm == 0) ? 1 : cpm);
    if (cell_idx < 0) d = -1 - $urandom_range(65535) / ((cpm == 0) ? 1 : cpm);
    d = org + d;
    return d[23:0];
  endfunction

  function automatic grid_op_t random_op();
    grid_op_t op;
    int pick;
    pick = $urandom_range(999);
    if (pick < 3) op.cmd = CMD_CLEAR;
    else if (pick < 150) op.cmd = CMD_LOAD;
    else if (pick < 450) op.cmd = CMD_DRAW;
    else if (pick < 880) op.cmd = CMD_SCORE;
    else if (pick < 950) op.cmd = CMD_RDCLR;
    else op.cmd = 3'($urandom_range(7, 5));
    op.px = coord(org_x, wdim);
    op.py = coord(org_y, hdim);
    op.wi = 4'($urandom);
    op.wv = 8'($urandom);
    return op;
  endfunction

  // result checking
  always @(posedge clk) begin
    grid_reply_t want;
    took_out = out_pop && !out_empty;
    if (took_out) begin
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected: score %0d status %0d",
               out_score, out_status);
        fail_count++;
      end else begin
        want = pending.pop_front();
        checked++;
        if (out_score !== want.score) begin
          $error("score: expected %0d, got %0d", want.score, out_score);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) out_pop <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    took_in = in_push && !in_full;
    if (took_in || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic row_t mk(logic [2:0] c, longint x, longint y, int wi, int wv,
                              bit typed = 0, longint sc = 0, logic [1:0] st = ST_DONE);
    row_t r;
    r.op.cmd = c;
    r.op.px = x[23:0];
    r.op.py = y[23:0];
    r.op.wi = 4'(wi);
    r.op.wv = 8'(wv);
    r.typed = typed;
    r.reply.score = sc[31:0];
    r.reply.status = st;
    return r;
  endfunction

  row_t directed [$];
  longint cfg_sets [5][6];

  initial begin
    foreach (grid_mem[i]) grid_mem[i] = 0;
    foreach (weights[i]) weights[i] = 0;
    score_acc = '0;
    org_x = 0; org_y = 0; cpm = 5120; wdim = 256; hdim = 256; rcnt = 15;
    build_circle();

    directed = '{
      mk(CMD_SCORE, 0, 0, 0, 0, 1, 0, ST_DONE),
      mk(CMD_RDCLR, 0, 0, 0, 0, 1, 0, ST_DONE),
      mk(CMD_LOAD, 0, 0, 0, 255, 1, 0, ST_DONE),
      mk(CMD_LOAD, 0, 0, 15, 0, 1, 0, ST_DONE),
      mk(CMD_LOAD, 0, 0, 1, 200),
      mk(CMD_LOAD, 0, 0, 7, 90),
      mk(CMD_LOAD, 0, 0, 14, 17),
      mk(CMD_DRAW, -13, 100, 0, 0, 1, 0, ST_OUTSIDE),
      mk(CMD_DRAW, 8388607, 0, 0, 0, 1, 0, ST_OUTSIDE),
      mk(CMD_DRAW, 0, -8388608, 0, 0, 1, 0, ST_OUTSIDE),
      mk(CMD_DRAW, -1, -1, 0, 0),
      mk(CMD_DRAW, 1000, 1000, 0, 0),
      mk(CMD_DRAW, 3263, 3263, 0, 0),
      mk(CMD_SCORE, 1000, 1000, 0, 0),
      mk(CMD_SCORE, 1013, 1000, 0, 0),
      mk(CMD_SCORE, 1090, 1000, 0, 0),
      mk(CMD_SCORE, -8388608, 8388607, 0, 0),
      mk(CMD_SCORE, 3263, 3263, 0, 0),
      mk(3'd5, 1000, 1000, 3, 9),
      mk(3'd6, 0, 0, 4, 10),
      mk(3'd7, -1, -1, 15, 255),
      mk(CMD_RDCLR, 0, 0, 0, 0),
      mk(CMD_CLEAR, 0, 0, 0, 0),
      mk(CMD_SCORE, 1000, 1000, 0, 0, 1, 0, ST_DONE)
    };

    cfg_sets = '{
      '{0, 0, 5120, 256, 256, 15},
      '{-8388608, 8388607 - 300000, 65535, 1, 256, 16},
      '{1234, -5000, 1, 256, 1, 1},
      '{-300000, 200000, 2560, 511, 40, 31},
      '{77, -77, 700, 0, 300, 0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (directed[i]) push_op(directed[i].op, directed[i].typed, directed[i].reply);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      for (int k = 0; k < 6; k++) write_reg(3'(k), cfg_sets[ph][k]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_op(random_op(), 0, '{default: '0});
        if (n == ITEMS_PER_PHASE / 2) drain();
      end
      drain();
    end

    while (pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("run covered %0d input transfers and %0d checked results", accepted, checked);
    $display("across 5 register settings, all commands, edge cells and idle/stall mixes");
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
